[sv/permutation_rank_defines.svh]
// Assertion macros shared by the permutation rank modules.
// Each one samples on clk_i and is switched off while rst_ni is low.
`ifndef PERMUTATION_RANK_DEFINES_SVH
`define PERMUTATION_RANK_DEFINES_SVH

`ifndef SYNTH
`define PRANK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("permutation_rank: assertion failed");
`define PRANK_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("permutation_rank: forbidden condition seen");
`else
`define PRANK_ASSERT(lbl, prop)
`define PRANK_ASSERT_NEVER(lbl, expr)
`endif

`endif

[sv/prank_pkg.sv]
package prank_pkg;

  localparam int MaxElements = 20;
  localparam int ElemW       = 5;
  localparam int RankW       = 62;
  localparam int DiffW       = ElemW + 1;

  // Configuration register indexes (word address bit 2).
  localparam logic RegPermSize = 1'b0;
  localparam logic RegEvenMode = 1'b1;

  localparam logic [ElemW-1:0] PermSizeReset = ElemW'(MaxElements);

  // One beat after the slot tables: what the accumulator needs for it.
  typedef struct packed {
    logic             used;    // this element contributes to the rank
    logic             last;    // this element completes the permutation
    logic [DiffW-1:0] diff;    // slot minus position, two's complement
    logic [ElemW-1:0] factor;  // n minus position
  } step_t;

endpackage

[sv/prank_slots.sv]
`include "permutation_rank_defines.svh"

module prank_slots (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [prank_pkg::ElemW-1:0]   element_i,
  input  logic [prank_pkg::ElemW-1:0]   perm_size_i,
  input  logic                          even_mode_i,
  output prank_pkg::step_t              step_o
);

  localparam logic [prank_pkg::ElemW-1:0] MaxN   = prank_pkg::ElemW'(prank_pkg::MaxElements);
  localparam logic [prank_pkg::ElemW-1:0] MaxIdx =
      prank_pkg::ElemW'(prank_pkg::MaxElements - 1);
  localparam logic [prank_pkg::ElemW-1:0] MinN   = prank_pkg::ElemW'(2);

  logic [prank_pkg::ElemW-1:0] pos_q, pos_d;
  logic [prank_pkg::ElemW-1:0] contents_q [prank_pkg::MaxElements];
  logic [prank_pkg::ElemW-1:0] slot_of_q  [prank_pkg::MaxElements];
  logic [prank_pkg::MaxElements-1:0] contents_vld_q, contents_vld_d;
  logic [prank_pkg::MaxElements-1:0] slot_of_vld_q, slot_of_vld_d;

  logic [prank_pkg::ElemW-1:0] n, used_cnt, value, slot, moved, pos_nxt;
  logic                        do_use, last;

  always_comb begin
    if (perm_size_i < MinN) begin
      n = MinN;
    end else if (perm_size_i > MaxN) begin
      n = MaxN;
    end else begin
      n = perm_size_i;
    end
    used_cnt = even_mode_i ? n - prank_pkg::ElemW'(2) : n - prank_pkg::ElemW'(1);
    value    = (element_i > MaxIdx) ? MaxIdx : element_i;
    // Entries never written since the last clear still hold the identity.
    slot     = slot_of_vld_q[value] ? slot_of_q[value] : value;
    moved    = contents_vld_q[pos_q] ? contents_q[pos_q] : pos_q;
    do_use   = pos_q < used_cnt;
    pos_nxt  = pos_q + prank_pkg::ElemW'(1);
    last     = pos_nxt >= n;
  end

  always_comb begin
    step_o.used   = do_use;
    step_o.last   = last;
    step_o.diff   = {1'b0, slot} - {1'b0, pos_q};
    step_o.factor = n - pos_q;
  end

  always_comb begin
    pos_d          = pos_q;
    contents_vld_d = contents_vld_q;
    slot_of_vld_d  = slot_of_vld_q;
    if (accept_i) begin
      if (last) begin
        pos_d          = '0;
        contents_vld_d = '0;
        slot_of_vld_d  = '0;
      end else begin
        pos_d = pos_nxt;
        if (do_use) begin
          contents_vld_d[slot] = 1'b1;
          slot_of_vld_d[moved] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      contents_vld_q <= '0;
      slot_of_vld_q  <= '0;
    end else begin
      pos_q          <= pos_d;
      contents_vld_q <= contents_vld_d;
      slot_of_vld_q  <= slot_of_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !last && do_use) begin
      contents_q[slot] <= moved;
      slot_of_q[moved] <= slot;
    end
  end

  `PRANK_ASSERT(pos_in_range_a, pos_q < MaxN)
  `PRANK_ASSERT(clear_on_last_a, (accept_i && last) |=> pos_q == '0 && contents_vld_q == '0)

endmodule

[sv/prank_accum.sv]
`include "permutation_rank_defines.svh"

module prank_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  prank_pkg::step_t              step_i,
  output logic [prank_pkg::RankW-1:0]   rank_o
);

  logic [prank_pkg::RankW-1:0] acc_q, acc_d;
  logic [prank_pkg::RankW-1:0] weight_q, weight_d;
  logic [prank_pkg::RankW-1:0] prod_lo, prod_corr, prod;

  // The difference is signed; weight * diff modulo 2^62 is the product with
  // its unsigned reading, less 64 * weight when the sign bit is set.
  always_comb begin
    prod_lo   = weight_q * prank_pkg::RankW'(step_i.diff);
    prod_corr = step_i.diff[prank_pkg::DiffW-1] ? (weight_q << prank_pkg::DiffW) : '0;
    prod      = prod_lo - prod_corr;
  end

  always_comb begin
    acc_d    = acc_q;
    weight_d = weight_q;
    if (advance_i) begin
      if (step_i.last) begin
        acc_d    = '0;
        weight_d = prank_pkg::RankW'(1);
      end else if (step_i.used) begin
        acc_d    = acc_q + prod;
        weight_d = weight_q * prank_pkg::RankW'(step_i.factor);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      weight_q <= prank_pkg::RankW'(1);
    end else begin
      acc_q    <= acc_d;
      weight_q <= weight_d;
    end
  end

  assign rank_o = acc_q;

  `PRANK_ASSERT(accum_clear_a,
      (advance_i && step_i.last) |=> acc_q == '0 && weight_q == prank_pkg::RankW'(1))

endmodule

[sv/permutation_rank.sv]
// Channel   Dir  Beat fields (low bit first)
// s_t*      in   tdata: perm_element[4:0], zero pad [7:5]
// m_t*      out  tdata: rank[61:0], zero pad [63:62]
// APB       in   perm_size at 0x0, even_parity_mode at 0x4
//
// One element is taken every cycle unless s_tready is low; it passes the slot
// tables in the cycle it is accepted and reaches the accumulator through p1_q.
// The rank of n elements reaches m_tdata via p1_q and the output register.
// Reset (rst_ni low, asynchronous) clears the tables, counters and m_tvalid at
// once; there is no clearing pass. s_tready drops only while a completed rank
// waits in the output register and the next completed rank is ready behind it.
`include "permutation_rank_defines.svh"

module permutation_rank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] perm_element, [7:5] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [61:0] rank, [63:62] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [prank_pkg::ElemW-1:0] perm_size_q;
  logic                        even_mode_q;
  logic                        cfg_wr;

  prank_pkg::step_t            step, p1_q;
  logic                        p1_vld_q;
  logic                        accept, stall, advance;
  logic [prank_pkg::RankW-1:0] acc_rank, rank_q;
  logic                        m_vld_q;

  // Registers sit on word addresses; only bit 2 selects between them.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_size_q <= prank_pkg::PermSizeReset;
      even_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        prank_pkg::RegPermSize: perm_size_q <= pwdata[prank_pkg::ElemW-1:0];
        prank_pkg::RegEvenMode: even_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      prank_pkg::RegPermSize: prdata = {{(32 - prank_pkg::ElemW){1'b0}}, perm_size_q};
      prank_pkg::RegEvenMode: prdata = {31'b0, even_mode_q};
      default:                prdata = '0;
    endcase
  end

  // A completed rank may move forward only when the output register is free.
  assign stall    = p1_vld_q && p1_q.last && m_vld_q && !m_tready;
  assign s_tready = !stall;
  assign accept   = s_tvalid && s_tready;
  assign advance  = p1_vld_q && !stall;

  prank_slots u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .element_i   (s_tdata[prank_pkg::ElemW-1:0]),
    .perm_size_i (perm_size_q),
    .even_mode_i (even_mode_q),
    .step_o      (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (s_tready) begin
      p1_vld_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_q <= step;
    end
  end

  prank_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .step_i    (p1_q),
    .rank_o    (acc_rank)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (advance && p1_q.last) begin
      m_vld_q <= 1'b1;
    end else if (m_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && p1_q.last) begin
      rank_q <= acc_rank;
    end
  end

  assign m_tvalid = m_vld_q;
  assign m_tdata  = {2'b00, rank_q};

  `PRANK_ASSERT(stall_cause_a, !s_tready |-> (p1_vld_q && p1_q.last && m_vld_q))
  `PRANK_ASSERT(rank_load_a, (advance && p1_q.last) |=> m_tvalid)
  `PRANK_ASSERT_NEVER(no_overwrite_a, advance && p1_q.last && m_vld_q && !m_tready)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int ItemTarget = 1900;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;

  // Tracks the ranking state of the block and the ranks it still owes.
  class rank_scoreboard;
    logic [prank_pkg::ElemW-1:0] size_reg;
    logic                        mode_reg;
    int                          pos;
    logic [prank_pkg::ElemW-1:0] contents [prank_pkg::MaxElements];
    logic [prank_pkg::ElemW-1:0] slot_of [prank_pkg::MaxElements];
    logic [prank_pkg::RankW-1:0] acc;
    logic [prank_pkg::RankW-1:0] weight;
    logic [prank_pkg::RankW-1:0] ranks_due [$];
    int                          errors;

    function new();
      size_reg = prank_pkg::PermSizeReset;
      mode_reg = 1'b0;
      errors   = 0;
      clear_perm();
    endfunction

    function void clear_perm();
      pos = 0;
      for (int k = 0; k < prank_pkg::MaxElements; k++) begin
        contents[k] = prank_pkg::ElemW'(k);
        slot_of[k]  = prank_pkg::ElemW'(k);
      end
      acc    = '0;
      weight = prank_pkg::RankW'(1);
    endfunction

    function int clamp_idx(int x);
      return (x >= prank_pkg::MaxElements) ? prank_pkg::MaxElements - 1 : x;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == prank_pkg::RegPermSize) size_reg = val[prank_pkg::ElemW-1:0];
      else mode_reg = val[0];
    endfunction

    function void note_element(logic [prank_pkg::ElemW-1:0] elem);
      int n, used, v, p, slot, moved;
      logic [prank_pkg::RankW-1:0] diff;
      n = int'(size_reg);
      if (n < 2) n = 2;
      if (n > prank_pkg::MaxElements) n = prank_pkg::MaxElements;
      used = mode_reg ? n - 2 : n - 1;
      v = clamp_idx(int'(elem));
      if (pos < used) begin
        p     = clamp_idx(pos);
        slot  = clamp_idx(int'(slot_of[v]));
        moved = clamp_idx(int'(contents[p]));
        slot_of[moved] = prank_pkg::ElemW'(slot);
        contents[slot] = prank_pkg::ElemW'(moved);
        // A slot below the position wraps modulo 2^62.
        diff   = prank_pkg::RankW'(slot) - prank_pkg::RankW'(pos);
        acc    = acc + weight * diff;
        weight = weight * prank_pkg::RankW'(n - pos);
      end
      pos++;
      if (pos >= n) begin
        ranks_due.push_back(acc);
        clear_perm();
      end
    endfunction

    function void check_rank(logic [63:0] data);
      logic [prank_pkg::RankW-1:0] want;
      if (ranks_due.size() == 0) begin
        $error("rank: unexpected beat, expected none, actual %0d",
               data[prank_pkg::RankW-1:0]);
        errors++;
      end else begin
        want = ranks_due.pop_front();
        if (data[prank_pkg::RankW-1:0] !== want) begin
          $error("rank: expected %0d, actual %0d", want, data[prank_pkg::RankW-1:0]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return ranks_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [4:0] perm_element, [7:5] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // [61:0] rank, [63:62] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rank_scoreboard board = new();

  int tx_idle_pct = 32;
  int rx_idle_pct = 32;
  int items_sent  = 0;
  int cycles      = 0;
  bit hold_req    = 1'b0;

  permutation_rank dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: checks every accepted beat and throttles tready.
  initial begin : rank_sink
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) board.check_rank(m_tdata);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_elem(int elem);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, elem[prank_pkg::ElemW-1:0]};
    do @(posedge clk_i); while (!s_tready);
    board.note_element(elem[prank_pkg::ElemW-1:0]);
    items_sent++;
  endtask

  // Stops sending and waits until every rank is out and the pipeline is empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, val);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(logic [prank_pkg::ElemW-1:0] sz, logic md);
    write_reg(prank_pkg::RegPermSize, {27'd0, sz});
    write_reg(prank_pkg::RegEvenMode, {31'd0, md});
    apb_release();
  endtask

  // kind 0: permutation, 1: random values, 2: wrong length.
  task automatic send_sequence(int n, bit even, int kind);
    int seq [prank_pkg::MaxElements];
    int len, j, k, tmp, inv;
    for (j = 0; j < n; j++) seq[j] = j;
    for (j = n - 1; j > 0; j--) begin
      k      = $urandom_range(j);
      tmp    = seq[j];
      seq[j] = seq[k];
      seq[k] = tmp;
    end
    if (even) begin
      inv = 0;
      for (j = 0; j < n; j++)
        for (k = j + 1; k < n; k++)
          if (seq[j] > seq[k]) inv++;
      if (inv % 2 == 1) begin
        tmp    = seq[0];
        seq[0] = seq[1];
        seq[1] = tmp;
      end
    end
    if (kind == 1) begin
      for (j = 0; j < n; j++) seq[j] = $urandom_range(31);
    end
    len = (kind == 2) ? $urandom_range(2 * n, 1) : n;
    for (j = 0; j < len; j++) send_elem(seq[j % n]);
  endtask

  initial begin : stimulus
    int phase, phase_end, n_eff, r, kind;
    logic [prank_pkg::ElemW-1:0] sz;
    logic md;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Partial permutation under the reset size, then the size shrinks below
    // the position: the next element completes it. Out-of-range values too.
    send_elem(19);
    send_elem(31);
    send_elem(0);
    send_elem(5);
    send_elem(7);
    send_elem(3);
    send_elem(12);
    send_elem(18);
    send_elem(1);
    send_elem(2);
    wait_idle();
    set_config(5'd4, 1'b0);
    send_elem(6);
    wait_idle();

    set_config(5'd2, 1'b0);
    send_elem(1);
    send_elem(0);
    send_elem(0);
    send_elem(1);
    wait_idle();

    set_config(5'd3, 1'b1);
    send_elem(2);
    send_elem(0);
    send_elem(1);
    wait_idle();

    // Size below two acts as two.
    set_config(5'd0, 1'b0);
    send_elem(31);
    send_elem(0);
    wait_idle();

    // Mode switched halfway through a permutation.
    set_config(5'd4, 1'b0);
    send_elem(3);
    send_elem(1);
    wait_idle();
    write_reg(prank_pkg::RegEvenMode, 32'd1);
    apb_release();
    send_elem(0);
    send_elem(2);

    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase)
        0: begin sz = 5'd31; md = 1'b1; end
        1: begin sz = 5'd2;  md = 1'b0; end
        2: begin sz = 5'd5;  md = 1'b0; end
        3: begin sz = 5'd1;  md = 1'b1; end
        4: begin sz = 5'd20; md = 1'b0; end
        5: begin sz = 5'd2;  md = 1'b1; end
        default: begin
          r  = $urandom_range(99);
          md = 1'($urandom_range(1));
          if (r < 10) begin
            case ($urandom_range(4))
              0: sz = 5'd0;
              1: sz = 5'd1;
              2: sz = 5'd2;
              3: sz = 5'd20;
              default: sz = 5'd31;
            endcase
          end else if (r < 75) begin
            sz = 5'($urandom_range(6, 2));
          end else begin
            sz = 5'($urandom_range(20, 7));
          end
        end
      endcase
      wait_idle();
      set_config(sz, md);
      n_eff = (sz < 2) ? 2 :
              ((sz > prank_pkg::MaxElements) ? prank_pkg::MaxElements : int'(sz));
      // Phase 2 is the long stretch without idling on either side.
      tx_idle_pct = (phase == 2) ? 0 : 32;
      rx_idle_pct = (phase == 2) ? 0 : 32;
      // Phase 1 holds off the result side while short permutations pile up.
      if (phase == 1) hold_req = 1'b1;
      phase_end = items_sent + ((phase == 2) ? 150 : $urandom_range(120, 40));
      while (items_sent < phase_end) begin
        r    = $urandom_range(99);
        kind = (r < 80) ? 0 : ((r < 92) ? 1 : 2);
        send_sequence(n_eff, md, kind);
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[permutation_rank.f]
+incdir+sv
sv/prank_pkg.sv
sv/prank_slots.sv
sv/prank_accum.sv
sv/permutation_rank.sv
tb/tb_top.sv
